[design/isotp_rr_pkg.sv]
// ============================================================================
// ISO-TP reassembly receiver package
// Shared types and protocol constants for the receiver front end, job queue
// and result sequencer.
// ============================================================================
package isotp_rr_pkg;

    // Input command codes.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Protocol control info, high nibble of byte0.
    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RX_ID           = 2'd0;
    localparam logic [1:0] CFG_FC_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] CFG_FC_ST_MIN       = 2'd2;
    localparam logic [1:0] CFG_SESSION_TIMEOUT = 2'd3;

    localparam int CFG_DATA_W = 29;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [2:0]  MAX_FRAME_BYTES = 3'd7;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FLOW_CTRL = 2'd1,
        KIND_SEQ_ERR   = 2'd2,
        KIND_TIMEOUT   = 2'd3
    } kind_t;

    // Result that follows the payload bytes of a job, if any.
    typedef enum logic [1:0] {
        TAIL_NONE     = 2'd0,
        TAIL_FLOW_CTRL = 2'd1,
        TAIL_SEQ_ERR  = 2'd2,
        TAIL_TIMEOUT  = 2'd3
    } tail_t;

    typedef struct packed {
        logic        cmd;
        logic [28:0] can_id;
        logic [3:0]  dlc;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [11:0] byte_index;
        logic [15:0] reply_id;
        logic        message_end;
        logic        last;
    } result_t;

    // One classified request: a run of payload bytes and an optional tail.
    typedef struct packed {
        logic [2:0]      nbytes;
        logic [6:0][7:0] data;
        logic [11:0]     base_index;
        logic            msg_end;
        tail_t           tail;
        logic [15:0]     reply_id;
    } job_t;

endpackage

[design/isotp_rr_front.sv]
// ============================================================================
// ISO-TP receiver front end
// Holds the configuration and session state, classifies each request and
// pushes a job describing its results into the queue if it yields any.
// ============================================================================
module isotp_rr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [isotp_rr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              accept,
    input  isotp_rr_pkg::item_t               item,
    output logic                              push,
    output isotp_rr_pkg::job_t                push_job
);
    import isotp_rr_pkg::*;

    logic [28:0] rx_id_reg;
    logic [15:0] timeout_reg;

    logic        receiving_reg, receiving_next;
    logic [11:0] remaining_reg, remaining_next;
    logic [3:0]  expected_seq_reg, expected_seq_next;
    logic [11:0] next_index_reg, next_index_next;
    logic [15:0] timer_reg, timer_next;

    logic [3:0]  pci;
    logic [3:0]  low_nibble;
    logic        own;
    logic [2:0]  sf_len;
    logic [11:0] ff_total;
    logic [2:0]  cf_cnt;
    logic [11:0] cf_left;
    logic [15:0] timer_inc;
    logic [15:0] limit;
    logic        has_job;
    job_t        job;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rx_id_reg   <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RX_ID:           rx_id_reg   <= cfg_data;
                CFG_SESSION_TIMEOUT: timeout_reg <= cfg_data[15:0];
                CFG_FC_BLOCK_SIZE,
                CFG_FC_ST_MIN:       ;
                default:             ;
            endcase
        end
    end

    assign pci        = item.byte0[7:4];
    assign low_nibble = item.byte0[3:0];
    assign own        = (item.dlc != 4'd0) &&
                        ((item.can_id == rx_id_reg) ||
                         (item.can_id == 29'd0 && pci == PCI_SINGLE));
    assign sf_len     = (low_nibble > 4'd7) ? MAX_FRAME_BYTES : low_nibble[2:0];
    assign ff_total   = {low_nibble, item.byte1};
    assign cf_cnt     = (remaining_reg > 12'd7) ? MAX_FRAME_BYTES : remaining_reg[2:0];
    assign cf_left    = remaining_reg - {9'd0, cf_cnt};
    assign timer_inc  = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
    assign limit      = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;

    always_comb begin
        receiving_next    = receiving_reg;
        remaining_next    = remaining_reg;
        expected_seq_next = expected_seq_reg;
        next_index_next   = next_index_reg;
        timer_next        = timer_reg;
        has_job           = 1'b0;
        job.nbytes        = 3'd0;
        job.data          = {item.byte7, item.byte6, item.byte5, item.byte4,
                             item.byte3, item.byte2, item.byte1};
        job.base_index    = 12'd0;
        job.msg_end       = 1'b1;
        job.tail          = TAIL_NONE;
        job.reply_id      = {item.byte2, item.byte3};

        if (item.cmd == CMD_TICK) begin
            if (receiving_reg) begin
                if (timer_inc >= limit) begin
                    has_job         = 1'b1;
                    job.tail        = TAIL_TIMEOUT;
                    job.msg_end     = 1'b0;
                    receiving_next  = 1'b0;
                    remaining_next  = 12'd0;
                    next_index_next = 12'd0;
                    timer_next      = 16'd0;
                end else begin
                    timer_next = timer_inc;
                end
            end
        end else if (own) begin
            if (pci == PCI_SINGLE) begin
                if (sf_len != 3'd0) begin
                    has_job         = 1'b1;
                    job.nbytes      = sf_len;
                    receiving_next  = 1'b0;
                    remaining_next  = 12'd0;
                    next_index_next = 12'd0;
                    timer_next      = 16'd0;
                end
            end else if (pci == PCI_FIRST) begin
                expected_seq_next = 4'd1;
                job.data          = {24'd0, item.byte7, item.byte6, item.byte5, item.byte4};
                timer_next        = 16'd0;
                if (ff_total <= 12'd4) begin
                    // Short message: it completes inside the first frame.
                    has_job         = (ff_total != 12'd0);
                    job.nbytes      = ff_total[2:0];
                    receiving_next  = 1'b0;
                    remaining_next  = 12'd0;
                    next_index_next = 12'd0;
                end else begin
                    has_job         = 1'b1;
                    job.nbytes      = 3'd4;
                    job.msg_end     = 1'b0;
                    job.tail        = TAIL_FLOW_CTRL;
                    receiving_next  = 1'b1;
                    remaining_next  = ff_total - 12'd4;
                    next_index_next = 12'd4;
                end
            end else if (pci == PCI_CONSECUTIVE && receiving_reg) begin
                has_job = 1'b1;
                if (low_nibble != expected_seq_reg) begin
                    job.tail        = TAIL_SEQ_ERR;
                    job.msg_end     = 1'b0;
                    receiving_next  = 1'b0;
                    remaining_next  = 12'd0;
                    next_index_next = 12'd0;
                    timer_next      = 16'd0;
                end else begin
                    job.nbytes        = cf_cnt;
                    job.base_index    = next_index_reg;
                    job.msg_end       = (cf_left == 12'd0);
                    expected_seq_next = expected_seq_reg + 4'd1;
                    if (cf_left == 12'd0) begin
                        receiving_next  = 1'b0;
                        remaining_next  = 12'd0;
                        next_index_next = 12'd0;
                        timer_next      = 16'd0;
                    end else begin
                        remaining_next  = cf_left;
                        next_index_next = next_index_reg + {9'd0, cf_cnt};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            receiving_reg    <= 1'b0;
            remaining_reg    <= '0;
            expected_seq_reg <= '0;
            next_index_reg   <= '0;
            timer_reg        <= '0;
        end else if (accept) begin
            receiving_reg    <= receiving_next;
            remaining_reg    <= remaining_next;
            expected_seq_reg <= expected_seq_next;
            next_index_reg   <= next_index_next;
            timer_reg        <= timer_next;
        end
    end

    assign push     = accept && has_job;
    assign push_job = job;

endmodule

[design/isotp_rr_queue.sv]
// ============================================================================
// ISO-TP receiver job queue
// Small register FIFO that decouples request classification from result
// sequencing.
// ============================================================================
module isotp_rr_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  isotp_rr_pkg::job_t push_job,
    input  logic               pop,
    output isotp_rr_pkg::job_t head_job,
    output logic               empty,
    output logic               full
);
    import isotp_rr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/isotp_rr_back.sv]
// ============================================================================
// ISO-TP receiver result sequencer
// Walks the job at the head of the queue one result per cycle while the
// output is not stalled, and holds the current result in an output register.
// ============================================================================
module isotp_rr_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    empty,
    input  isotp_rr_pkg::job_t      head_job,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output isotp_rr_pkg::result_t   result
);
    import isotp_rr_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    result_t    result_reg;
    result_t    cur;
    logic       load;
    logic       in_bytes;
    logic       last_byte;

    assign load      = !empty && (!valid_reg || !result_stall);
    assign in_bytes  = (pos_reg < head_job.nbytes);
    assign last_byte = (pos_reg == head_job.nbytes - 3'd1);

    always_comb begin
        cur.kind         = KIND_PAYLOAD;
        cur.payload_byte = 8'd0;
        cur.byte_index   = 12'd0;
        cur.reply_id     = 16'd0;
        cur.message_end  = 1'b0;
        cur.last         = 1'b1;
        if (in_bytes) begin
            cur.payload_byte = head_job.data[pos_reg];
            cur.byte_index   = head_job.base_index + {9'd0, pos_reg};
            cur.message_end  = head_job.msg_end && last_byte;
            cur.last         = last_byte && (head_job.tail == TAIL_NONE);
        end else begin
            unique case (head_job.tail)
                TAIL_FLOW_CTRL: begin
                    cur.kind     = KIND_FLOW_CTRL;
                    cur.reply_id = head_job.reply_id;
                end
                TAIL_SEQ_ERR:   cur.kind = KIND_SEQ_ERR;
                TAIL_TIMEOUT:   cur.kind = KIND_TIMEOUT;
                TAIL_NONE:      cur.kind = KIND_PAYLOAD;
                default:        cur.kind = KIND_PAYLOAD;
            endcase
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (cur.last) begin
                pos_next = 3'd0;
                pop      = 1'b1;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end else if (!result_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            result_reg <= cur;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

[design/isotp_reassembly_receiver_unit.sv]
// ============================================================================
// ISO-TP reassembly receiver
// Reassembles ISO-TP messages from received CAN frames and session ticks.
// ============================================================================
// Requests enter on item/item_valid and are taken at an edge where item_valid
// is high and item_stall is low. A request is a CAN frame or one timer tick.
// Each request yields zero to seven results on result/result_valid; a result
// is taken at an edge where result_valid is high and result_stall is low, and
// the final result of a request carries last.
// A request is classified in the cycle it is accepted and, if it yields any
// results, its job is written to a job queue of QUEUE_DEPTH entries. From the
// queue head the sequencer loads each result into the output register, one
// result per cycle while result_stall is low. item_stall is high only while
// the job queue is full. When the receiver stalls, the output register holds
// its result and the queue keeps absorbing requests until it fills.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data; the
// user must write it only while the block is idle, as the block does not
// enforce this. Reset clears the session state, sets the session timeout to
// 100 ticks and empties the queue and output register.
// ============================================================================
module isotp_reassembly_receiver_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [isotp_rr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  isotp_rr_pkg::item_t                 item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output isotp_rr_pkg::result_t               result
);
    import isotp_rr_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    job_t push_job;
    job_t head_job;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    isotp_rr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .push      (push),
        .push_job  (push_job)
    );

    isotp_rr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    isotp_rr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[dv/isotp_reassembly_receiver_unit_tb.sv]
// ============================================================================
// ISO-TP reassembly receiver testbench
// Drives CAN frames and session ticks into the receiver and predicts every
// result: payload bytes, flow-control requests, sequence errors and session
// timeouts. Directed cases come first, then randomized multi-frame traffic
// under several register settings with random sender gaps and receiver stalls.
// ============================================================================
module isotp_reassembly_receiver_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import isotp_rr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 100;
    localparam int MAX_REPORTS = 50;

    localparam logic [3:0] PCI_FLOW_CTRL = 4'h3;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [1:0]        cfg_index    = CFG_RX_ID;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;

    // Results still owed by the block, oldest first.
    result_t           pending_results[$];
    result_t           want;

    int  errors        = 0;
    int  useful_items  = 0;
    int  cycle_count   = 0;
    int  burst_left    = 0;
    int  drain_wait    = 0;
    bit  steady_sender = 1'b0;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;
    int  stall_mode    = STALL_NONE;
    int  stall_left    = 0;
    int  stall_phase   = 0;

    // Register mirror.
    logic [28:0] cfg_rx_id      = '0;
    logic [7:0]  cfg_block_size = '0;
    logic [7:0]  cfg_st_min     = '0;
    logic [15:0] cfg_timeout    = TIMEOUT_RESET;

    // Session state mirror.
    bit          msg_open   = 1'b0;
    logic [11:0] bytes_left = '0;
    logic [11:0] idx_next   = '0;
    logic [3:0]  seq_next   = '0;
    logic [15:0] reply_tgt  = '0;
    logic [15:0] tick_count = '0;

    isotp_reassembly_receiver_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver side: randomly chosen stretches of no stall, random stall and a
    // periodic stall, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
                stall_left = $urandom_range(10, 80);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
                STALL_NONE:   result_stall <= 1'b0;
                STALL_RANDOM: result_stall <= ($urandom_range(0, 1) == 1);
                default:      result_stall <= (stall_phase % 4 == 3);
            endcase
        end
    end

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result kind %0d byte %0d index %0d expected none",
                             $time, result.kind, result.payload_byte, result.byte_index);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, result.kind);
                check_field("payload_byte", want.payload_byte, result.payload_byte);
                check_field("byte_index", want.byte_index, result.byte_index);
                check_field("reply_id", want.reply_id, result.reply_id);
                check_field("message_end", want.message_end, result.message_end);
                check_field("last", want.last, result.last);
            end
        end
    end

    function automatic result_t make_result(input kind_t k, input logic [7:0] pb,
                                            input logic [11:0] idx,
                                            input logic [15:0] rid, input logic mend);
        result_t r;
        r.kind         = k;
        r.payload_byte = pb;
        r.byte_index   = idx;
        r.reply_id     = rid;
        r.message_end  = mend;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic void close_message();
        msg_open   = 1'b0;
        bytes_left = '0;
        idx_next   = '0;
        tick_count = '0;
    endfunction

    // Works out the results of one accepted request and queues them.
    function automatic void predict(input item_t it);
        result_t         batch[$];
        result_t         r;
        logic [0:7][7:0] b;
        logic [3:0]      pci;
        logic [11:0]     total;
        int unsigned     len;
        int unsigned     cnt;
        bit              own;
        bit              acted;
        b     = {it.byte0, it.byte1, it.byte2, it.byte3,
                 it.byte4, it.byte5, it.byte6, it.byte7};
        pci   = it.byte0[7:4];
        acted = 1'b0;
        if (it.cmd == CMD_TICK)
        begin
            if (msg_open)
            begin
                acted = 1'b1;
                if (tick_count != 16'hFFFF)
                    tick_count++;
                // A zero timeout behaves as one tick.
                if (tick_count >= ((cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout))
                begin
                    batch.push_back(make_result(KIND_TIMEOUT, 8'd0, 12'd0, 16'd0, 1'b0));
                    close_message();
                end
            end
        end
        else if (it.dlc != 4'd0)
        begin
            // Identifier zero is accepted for single frames only.
            own = (it.can_id == cfg_rx_id) || (it.can_id == 29'd0 && pci == PCI_SINGLE);
            if (own && pci == PCI_SINGLE)
            begin
                len = (it.byte0[3:0] > 4'd7) ? 7 : it.byte0[3:0];
                if (len != 0)
                begin
                    acted = 1'b1;
                    close_message();
                    for (int i = 0; i < len; i++)
                        batch.push_back(make_result(KIND_PAYLOAD, b[1 + i], 12'(i), 16'd0,
                                                    i == len - 1));
                end
            end
            else if (own && pci == PCI_FIRST)
            begin
                acted = 1'b1;
                total = {it.byte0[3:0], it.byte1};
                close_message();
                reply_tgt = {it.byte2, it.byte3};
                seq_next  = 4'd1;
                if (total <= 12'd4)
                begin
                    for (int i = 0; i < total; i++)
                        batch.push_back(make_result(KIND_PAYLOAD, b[4 + i], 12'(i), 16'd0,
                                                    i == total - 1));
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        batch.push_back(make_result(KIND_PAYLOAD, b[4 + i], 12'(i), 16'd0,
                                                    1'b0));
                    batch.push_back(make_result(KIND_FLOW_CTRL, 8'd0, 12'd0, reply_tgt, 1'b0));
                    msg_open   = 1'b1;
                    bytes_left = total - 12'd4;
                    idx_next   = 12'd4;
                    tick_count = '0;
                end
            end
            else if (own && pci == PCI_CONSECUTIVE && msg_open)
            begin
                acted = 1'b1;
                if (it.byte0[3:0] != seq_next)
                begin
                    batch.push_back(make_result(KIND_SEQ_ERR, 8'd0, 12'd0, 16'd0, 1'b0));
                    close_message();
                end
                else
                begin
                    cnt = (bytes_left > 12'd7) ? 7 : bytes_left;
                    for (int i = 0; i < cnt; i++)
                        batch.push_back(make_result(KIND_PAYLOAD, b[1 + i],
                                                    12'(idx_next + i), 16'd0,
                                                    bytes_left == cnt && i == cnt - 1));
                    bytes_left = 12'(bytes_left - cnt);
                    idx_next   = 12'(idx_next + cnt);
                    seq_next   = seq_next + 4'd1;
                    if (bytes_left == 12'd0)
                        close_message();
                end
            end
        end
        if (acted)
            useful_items++;
        for (int i = 0; i < batch.size(); i++)
        begin
            r      = batch[i];
            r.last = (i == batch.size() - 1);
            pending_results.push_back(r);
        end
    endfunction

    function automatic logic [55:0] rand_data();
        return {$urandom(), $urandom()};
    endfunction

    function automatic item_t frame(input logic [28:0] id, input logic [3:0] dlc,
                                    input logic [7:0] pci_byte, input logic [55:0] data);
        item_t it;
        it.cmd    = CMD_FRAME;
        it.can_id = id;
        it.dlc    = dlc;
        it.byte0  = pci_byte;
        {it.byte1, it.byte2, it.byte3, it.byte4, it.byte5, it.byte6, it.byte7} = data;
        return it;
    endfunction

    function automatic item_t tick_item();
        item_t it;
        it     = frame($urandom(), $urandom_range(0, 8), $urandom(), rand_data());
        it.cmd = CMD_TICK;
        return it;
    endfunction

    function automatic item_t single_frame(input logic [28:0] id, input logic [3:0] len);
        return frame(id, $urandom_range(1, 8), {PCI_SINGLE, len}, rand_data());
    endfunction

    function automatic item_t first_frame(input logic [11:0] total, input logic [15:0] reply);
        logic [55:0] d;
        d         = rand_data();
        d[55:32]  = {total[7:0], reply};
        return frame(cfg_rx_id, $urandom_range(1, 8), {PCI_FIRST, total[11:8]}, d);
    endfunction

    function automatic item_t consecutive(input logic [3:0] seq);
        return frame(cfg_rx_id, $urandom_range(1, 8), {PCI_CONSECUTIVE, seq}, rand_data());
    endfunction

    // Offers one request and holds it until taken. The sender runs in bursts
    // of random length with random gaps between them, unless steady_sender is set.
    task automatic send(input item_t it);
        int gap;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predict(it);
        if (!steady_sender)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = $urandom_range(1, 8);
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    // Stops offering requests, waits until every predicted result has been taken
    // and then waits out IDLE_CYCLES before the block counts as idle.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [28:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_RX_ID:         cfg_rx_id      = value;
            CFG_FC_BLOCK_SIZE: cfg_block_size = value[7:0];
            CFG_FC_ST_MIN:     cfg_st_min     = value[7:0];
            default:           cfg_timeout    = value[15:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [28:0] rx, input logic [7:0] bs,
                              input logic [7:0] st, input logic [15:0] limit);
        wait_idle();
        write_reg(CFG_RX_ID, rx);
        write_reg(CFG_FC_BLOCK_SIZE, {21'd0, bs});
        write_reg(CFG_FC_ST_MIN, {21'd0, st});
        write_reg(CFG_SESSION_TIMEOUT, {13'd0, limit});
    endtask

    task automatic send_noise();
        int          pick;
        logic [28:0] id;
        logic [7:0]  pb;
        pick = $urandom_range(0, 3);
        id   = $urandom();
        pb   = $urandom();
        case (pick)
            0: send(frame(id, $urandom_range(0, 8), pb, rand_data()));
            1: send(frame(cfg_rx_id, 4'd0, pb, rand_data()));
            2:
            begin
                // Flow control or an unknown control type on our own id.
                pb[7:4] = $urandom_range(PCI_FLOW_CTRL, 15);
                send(frame(cfg_rx_id, $urandom_range(1, 8), pb, rand_data()));
            end
            default:
            begin
                pb[7:4] = $urandom_range(1, 15);
                send(frame(29'd0, $urandom_range(1, 8), pb, rand_data()));
            end
        endcase
    endtask

    // One multi-frame message, mostly well formed, sometimes broken off.
    task automatic run_message(input logic [11:0] total);
        int          pick;
        logic [3:0]  seq;
        logic [11:0] left;
        send(first_frame(total, $urandom()));
        seq  = 4'd1;
        left = (total > 12'd4) ? total - 12'd4 : 12'd0;
        while (left != 12'd0 && msg_open)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send(tick_item());
            else if (pick < 12)
                send_noise();
            else if (pick < 14)
                send(consecutive(seq + $urandom_range(1, 15)));
            else if (pick < 15)
                left = 12'd0;
            else
            begin
                send(consecutive(seq));
                seq  = seq + 4'd1;
                left = (left > 12'd7) ? left - 12'd7 : 12'd0;
            end
        end
    endtask

    task automatic test_reset_state();
        // Out of reset the receive id is zero.
        send(frame(29'd0, 4'd8, 8'h07, 56'hFF_FF_FF_FF_FF_FF_FF));
        send(tick_item());
        set_config(29'h1FFF_FFFF, 8'hFF, 8'hFF, TIMEOUT_RESET);
    endtask

    task automatic test_single_frames();
        send(frame(cfg_rx_id, 4'd8, 8'h0F, 56'h0));
        // Bytes past the data length code are still delivered.
        send(frame(29'd0, 4'd1, 8'h03, 56'hA5_5A_C3_00_00_00_00));
        send(single_frame(cfg_rx_id, 4'd0));
        send(frame(cfg_rx_id, 4'd0, 8'h05, rand_data()));
        send(frame(29'd0, 4'd8, 8'h1F, rand_data()));
        send(frame(cfg_rx_id, 4'd3, {PCI_FLOW_CTRL, 4'h0}, rand_data()));
        send(frame(cfg_rx_id, 4'd8, 8'hF5, rand_data()));
    endtask

    task automatic test_first_frame_lengths();
        send(first_frame(12'd0, 16'h1234));
        send(first_frame(12'd1, 16'h1234));
        send(first_frame(12'd4, 16'h1234));
        send(first_frame(12'd5, 16'h0000));
        send(consecutive(4'd1));
        send(consecutive(4'd2));
    endtask

    task automatic test_sequence_errors();
        send(first_frame(12'hFFF, 16'hFFFF));
        send(consecutive(4'd1));
        send(consecutive(4'd3));
        send(first_frame(12'd20, $urandom()));
        // A new first frame restarts, a single frame drops the message.
        send(first_frame(12'd30, $urandom()));
        send(single_frame(cfg_rx_id, 4'd2));
        send(consecutive(4'd1));
    endtask

    task automatic test_session_timeout();
        set_config(cfg_rx_id, cfg_block_size, cfg_st_min, 16'd0);
        send(first_frame(12'd10, $urandom()));
        send(tick_item());
        set_config(cfg_rx_id, cfg_block_size, cfg_st_min, 16'd2);
        send(first_frame(12'd9, 16'h0000));
        send(tick_item());
        send(consecutive(4'd1));
        send(tick_item());
        send(tick_item());
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_request  = 1'b1;
        steady_sender = 1'b1;
        for (int k = 0; k < 8; k++)
            send(single_frame(cfg_rx_id, 4'd7));
        steady_sender = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int          goal;
        int          pick;
        logic [11:0] len;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_config($urandom(), 8'h00, 8'h00, 16'd4);
                1:       set_config(29'd0, $urandom(), $urandom(), 16'hFFFF);
                2:       set_config(29'h1FFF_FFFF, $urandom(), $urandom(), 16'd1);
                default: set_config($urandom(), $urandom(), $urandom(), $urandom_range(2, 12));
            endcase
            // Long enough for the sequence number to wrap.
            if (phase == 1)
                run_message(12'd130);
            goal = useful_items + 50;
            while (useful_items < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10)
                        len = $urandom_range(0, 4);
                    else if (pick < 18)
                        len = $urandom_range(100, 140);
                    else
                        len = $urandom_range(5, 40);
                    run_message(len);
                end
                else if (pick < 75)
                    send(single_frame(($urandom_range(0, 3) == 0) ? 29'd0 : cfg_rx_id,
                                      $urandom_range(0, 15)));
                else if (pick < 85)
                    send(tick_item());
                else
                    send_noise();
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_single_frames();
        test_first_frame_lengths();
        test_sequence_errors();
        test_session_timeout();
        test_backpressure();
        test_random_traffic();
        item_valid <= 1'b0;
        while (pending_results.size() != 0 && drain_wait < 4000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (IDLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
design/isotp_rr_pkg.sv
design/isotp_rr_front.sv
design/isotp_rr_queue.sv
design/isotp_rr_back.sv
design/isotp_reassembly_receiver_unit.sv
dv/isotp_reassembly_receiver_unit_tb.sv
